>>> rtl/swpt_pkg.sv
package swpt_pkg;

	localparam int TS_W   = 64;
	localparam int AGE_W  = 32;
	localparam int PCT_W  = 7;
	localparam int HELD_W = 7;

	localparam int WINDOW_DEPTH_DEF = 64;

	localparam logic [PCT_W-1:0] PCT_RESET = 7'd95;
	localparam logic [PCT_W-1:0] PCT_MIN   = 7'd1;
	localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
	localparam int               RANK_DIV  = 100;
	localparam int               RANK_RND  = 99;

	localparam logic [AGE_W-1:0] AGE_SAT = '1;

	typedef struct packed {
		logic [TS_W-1:0] submitted_time_ns;
		logic [TS_W-1:0] received_time_ns;
	} swpt_in_t;

	typedef struct packed {
		logic [AGE_W-1:0]  age_ns;
		logic [AGE_W-1:0]  percentile_age_ns;
		logic [HELD_W-1:0] samples_held;
	} swpt_out_t;

	// one sorted slot of the chain
	typedef struct packed {
		logic             vld;
		logic [AGE_W-1:0] val;
	} swpt_cell_t;

	// broadcast to every cell
	typedef struct packed {
		logic             upd;
		logic             del;
		logic [AGE_W-1:0] del_val;
		logic [AGE_W-1:0] ins_val;
	} swpt_cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_SEL
	} swpt_state_t;

endpackage

>>> rtl/swpt_cell.sv
module swpt_cell
	import swpt_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head,
	input  swpt_cell_ctl_t ctl,
	input  swpt_cell_t     prev,
	input  swpt_cell_t     next,
	output swpt_cell_t     cur
);

	logic             vld_q;
	logic [AGE_W-1:0] val_q;
	swpt_cell_t       own;
	swpt_cell_t       pd_self;
	swpt_cell_t       pd_prev;
	swpt_cell_t       nxt;
	logic             gt_self;
	logic             gt_prev;

	assign own = '{vld: vld_q, val: val_q};
	assign cur = own;

	always_comb begin
		// removal of the oldest age: equal ages sit oldest first, so every
		// cell at or above the removed value pulls from its right neighbor
		pd_self = own;
		if (ctl.del && own.vld && own.val >= ctl.del_val) begin
			pd_self = next;
		end
		pd_prev = prev;
		if (!head && ctl.del && prev.vld && prev.val >= ctl.del_val) begin
			pd_prev = own;
		end

		// insertion after all equal ages
		gt_self = !pd_self.vld || (pd_self.val > ctl.ins_val);
		gt_prev = !head && (!pd_prev.vld || (pd_prev.val > ctl.ins_val));
		nxt = pd_self;
		if (gt_self) begin
			if (gt_prev) begin
				nxt = pd_prev;
			end else begin
				nxt = '{vld: 1'b1, val: ctl.ins_val};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.upd) begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			val_q <= nxt.val;
		end
	end

endmodule

>>> rtl/swpt_age_ring.sv
module swpt_age_ring
	import swpt_pkg::*;
#(
	parameter int DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [AGE_W-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [AGE_W-1:0]         rdata
);

	logic [AGE_W-1:0] mem [DEPTH];
	logic [AGE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/sliding_window_percentile_tracker_unit.sv
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | swpt_in_t: submit and receive stamps
// out     | output    | out_valid/out_stall | swpt_out_t: age, percentile, count
// cfg     | input     | cfg_valid/cfg_ready | percentile_pct, always ready
//
// an item passes from accept to result through stamp and ring read, then a
// chain update in which every cell of the sorted chain removes the oldest
// age and inserts the new one, then the rank select; the next item is taken
// during the select cycle, and none is taken while the chain updates.
// a result waiting on out_stall holds the select stage and stalls the input.
// reset clears the chain valid bits, fill count and write slot; the ring
// memory needs no clearing pass since a slot is only read once written.
module sliding_window_percentile_tracker_unit
	import swpt_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  swpt_in_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output swpt_out_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [PCT_W-1:0] cfg_data
);

	localparam int IDX_W    = $clog2(WINDOW_DEPTH);
	localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
	localparam int PROD_W   = $clog2(WINDOW_DEPTH * RANK_DIV + RANK_DIV);
	localparam int RECIP_SH = PROD_W + 7;
	localparam int RECIP_W  = RECIP_SH - 6;
	localparam int Q_W      = PROD_W + RECIP_W;
	localparam longint unsigned RECIP =
		((64'd1 << RECIP_SH) + RANK_RND) / RANK_DIV;

	localparam logic [CNT_W-1:0] FULL     = CNT_W'(WINDOW_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

	swpt_state_t state_q;
	swpt_state_t state_nxt;

	logic [PCT_W-1:0]  pct_q;
	logic [PCT_W-1:0]  pct_eff;
	logic [IDX_W-1:0]  wslot_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  fill_nxt;

	logic [AGE_W-1:0]  age_s1;
	logic              del_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [Q_W-1:0]    q_s2;
	logic [AGE_W-1:0]  oldest_age;

	logic [TS_W-1:0]   diff;
	logic [AGE_W-1:0]  age_in;

	logic              in_acc;
	logic              out_free;
	logic              do_upd;
	logic              do_sel;

	logic [IDX_W-1:0]  rank_k;
	logic [CNT_W-1:0]  rank_c;
	logic [AGE_W-1:0]  sel_val;

	swpt_out_t         out_q;
	logic              out_valid_q;

	swpt_cell_ctl_t    cell_ctl;
	swpt_cell_t        cell_cur  [WINDOW_DEPTH];
	swpt_cell_t        cell_prev [WINDOW_DEPTH];
	swpt_cell_t        cell_next [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] cell_vld;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= PCT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pct_q <= cfg_data;
		end
	end

	always_comb begin
		pct_eff = pct_q;
		if (pct_q < PCT_MIN) begin
			pct_eff = PCT_MIN;
		end else if (pct_q > PCT_MAX) begin
			pct_eff = PCT_MAX;
		end
	end

	// control
	assign out_free = !out_valid_q || !out_stall;
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_UPD;
				end
			end
			ST_UPD: begin
				state_nxt = ST_SEL;
			end
			ST_SEL: begin
				if (out_free) begin
					state_nxt = in_valid ? ST_UPD : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		do_upd   = 1'b0;
		do_sel   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_UPD: begin
				do_upd = 1'b1;
			end
			ST_SEL: begin
				in_stall = !out_free;
				do_sel   = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// accept stage: age, fill count and rank numerator
	assign diff   = (in_data.received_time_ns >= in_data.submitted_time_ns) ?
		(in_data.received_time_ns - in_data.submitted_time_ns) : '0;
	assign age_in = (diff[TS_W-1:AGE_W] != '0) ? AGE_SAT : diff[AGE_W-1:0];

	assign fill_nxt = (fill_q == FULL) ? fill_q : fill_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			wslot_q <= '0;
		end else begin
			if (in_acc) begin
				fill_q <= fill_nxt;
			end
			if (do_upd) begin
				wslot_q <= (wslot_q == LAST_IDX) ? '0 : wslot_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			age_s1  <= age_in;
			del_s1  <= (fill_q == FULL);
			prod_s1 <= PROD_W'(fill_nxt) * PROD_W'(pct_eff) + PROD_W'(RANK_RND);
		end
		if (do_upd) begin
			q_s2 <= Q_W'(prod_s1) * Q_W'(RECIP);
		end
	end

	// oldest age leaves the window once it is full
	swpt_age_ring #(
		.DEPTH(WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (do_upd),
		.waddr (wslot_q),
		.wdata (age_s1),
		.re    (in_acc),
		.raddr (wslot_q),
		.rdata (oldest_age)
	);

	// sorted chain
	assign cell_ctl = '{upd: do_upd, del: del_s1, del_val: oldest_age, ins_val: age_s1};

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_prev[i] = '0;
		end else begin : g_mid
			assign cell_prev[i] = cell_cur[i-1];
		end
		if (i == WINDOW_DEPTH - 1) begin : g_tail
			assign cell_next[i] = '0;
		end else begin : g_body
			assign cell_next[i] = cell_cur[i+1];
		end

		swpt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.head   ((i == 0) ? 1'b1 : 1'b0),
			.ctl    (cell_ctl),
			.prev   (cell_prev[i]),
			.next   (cell_next[i]),
			.cur    (cell_cur[i])
		);

		assign cell_vld[i] = cell_cur[i].vld;
	end

	// rank select: k = ceil(count * pct / 100) - 1 by reciprocal multiply
	assign rank_c = q_s2[RECIP_SH +: CNT_W] - CNT_W'(1);
	assign rank_k = rank_c[IDX_W-1:0];

	always_comb begin
		sel_val = '0;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			if (IDX_W'(i) == rank_k) begin
				sel_val = sel_val | cell_cur[i].val;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_sel) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_sel) begin
			out_q.age_ns            <= age_s1;
			out_q.percentile_age_ns <= sel_val;
			out_q.samples_held      <= HELD_W'(fill_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_upd_to_sel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |=> state_q == ST_SEL)
		else $error("chain update not followed by rank select");

	a_sel_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEL && !out_free |-> !in_acc ##1 state_q == ST_SEL)
		else $error("select stage left while result still blocked");

	a_chain_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEL |-> $countones(cell_vld) == int'(fill_q))
		else $error("chain valid cells disagree with fill count");

	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEL |-> rank_c < fill_q)
		else $error("rank beyond held ages");

endmodule
